// ----- hdl/duts_pkg.sv -----
package duts_pkg;

  // Fixed widths of the item fields and configuration registers
  localparam int TIME_W  = 24;
  localparam int COUNT_W = 16;
  localparam int MODE_W  = 4;
  localparam int CFG_IDX_W = 3;

  // Defaults for the top-level parameters
  localparam int DEF_TIME_BITS     = 24;
  localparam int DEF_COUNT_BITS    = 16;
  localparam int DEF_START_BACKOFF = 30;

  // mode_bits positions
  localparam int MODE_CELL_EN  = 0;
  localparam int MODE_SAT_EN   = 1;
  localparam int MODE_PASS_WIN = 2;
  localparam int MODE_CELL_WIN = 3;

  typedef enum logic [2:0] {
    OP_START       = 3'd0,
    OP_TICK        = 3'd1,
    OP_UPDATE      = 3'd2,
    OP_CELL_RESULT = 3'd3,
    OP_SAT_RESULT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_CELL = 2'd1,
    REQ_SAT  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_MIN_INTERVAL  = 3'd0,
    REG_CELL_MAX_INTERVAL  = 3'd1,
    REG_CELL_MIN_UPDATES   = 3'd2,
    REG_CELL_BACKOFF_LIMIT = 3'd3,
    REG_SAT_MIN_INTERVAL   = 3'd4,
    REG_SAT_MAX_INTERVAL   = 3'd5,
    REG_SAT_MIN_UPDATES    = 3'd6,
    REG_MODE_BITS          = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  cell_min_interval;
    logic [TIME_W-1:0]  cell_max_interval;
    logic [COUNT_W-1:0] cell_min_updates;
    logic [TIME_W-1:0]  cell_backoff_limit;
    logic [TIME_W-1:0]  sat_min_interval;
    logic [TIME_W-1:0]  sat_max_interval;
    logic [COUNT_W-1:0] sat_min_updates;
    logic [MODE_W-1:0]  mode_bits;
  } cfg_regs_t;

  typedef struct packed {
    op_t               operation;
    logic              success;
    logic [TIME_W-1:0] pass_delay;
  } item_t;

  typedef struct packed {
    req_t              request;
    logic              max_backoff_hit;
    logic [TIME_W-1:0] retry_wait;
  } result_t;

endpackage

// ----- hdl/dual_uplink_transmit_scheduler.sv -----
// Decides when to start a cellular connection or a satellite transmission. Feed it
// beats of start, one-second tick, position update and connection result; every beat
// returns exactly one result beat with the request code (only ever nonzero on a tick),
// a max-backoff flag and the retry wait loaded on a cellular failure. The block takes a
// new beat every cycle unless the result register stalls; an accepted beat is held in
// the input register, then takes the single pass of update logic into the result
// register. A stalled result register holds, and the input register still takes one
// more beat behind it. Write configuration only while the block is idle; mode bits
// are read live, not latched at start. Reset behaves like power-up: no request can
// be issued before a start beat.
module dual_uplink_transmit_scheduler import duts_pkg::*; #(
  parameter int TIME_BITS     = DEF_TIME_BITS,
  parameter int COUNT_BITS    = DEF_COUNT_BITS,
  parameter int START_BACKOFF = DEF_START_BACKOFF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [0] success, [24:1] pass_delay, rest zero
  input  logic [2:0]           in_tuser,   // [2:0] operation
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [0] max_backoff_hit, [24:1] retry_wait, rest zero
  output logic [1:0]           out_tuser,  // [1:0] request
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  cfg_regs_t cfg_r;

  // Input register
  logic  s1_valid_r;
  item_t s1_item_r;

  // Result register
  logic    out_valid_r;
  result_t out_res_r;

  result_t step_res;
  logic    advance;

  // Move the held beat on whenever the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers: all writes land, unknown index impossible at 3 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CELL_MIN_INTERVAL:  cfg_r.cell_min_interval  <= cfg_data;
        REG_CELL_MAX_INTERVAL:  cfg_r.cell_max_interval  <= cfg_data;
        REG_CELL_MIN_UPDATES:   cfg_r.cell_min_updates   <= cfg_data[COUNT_W-1:0];
        REG_CELL_BACKOFF_LIMIT: cfg_r.cell_backoff_limit <= cfg_data;
        REG_SAT_MIN_INTERVAL:   cfg_r.sat_min_interval   <= cfg_data;
        REG_SAT_MAX_INTERVAL:   cfg_r.sat_max_interval   <= cfg_data;
        REG_SAT_MIN_UPDATES:    cfg_r.sat_min_updates    <= cfg_data[COUNT_W-1:0];
        REG_MODE_BITS:          cfg_r.mode_bits          <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture a beat whenever the slot is free or emptying
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.operation  <= op_t'(in_tuser);
      s1_item_r.success    <= in_tdata[0];
      s1_item_r.pass_delay <= in_tdata[TIME_W:1];
    end
  end

  duts_engine #(
    .TIME_BITS     (TIME_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .START_BACKOFF (START_BACKOFF)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .result  (step_res)
  );

  // Result register: hold while stalled, refill from the engine on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.request;
  assign out_tdata  = {{(32 - TIME_W - 1){1'b0}}, out_res_r.retry_wait,
                       out_res_r.max_backoff_hit};

  // A request never travels with failure information
  a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != REQ_NONE) |-> (out_tdata[TIME_W:0] == '0))
    else $error("request issued together with retry information");

  // An empty input register must always take a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled while its register is empty");

  // An accepted beat is held in the input register next cycle
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted beat lost");

  // Every engine step produces a visible result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_tvalid)
    else $error("engine step without result beat");

endmodule

// ----- hdl/duts_engine.sv -----
module duts_engine import duts_pkg::*; #(
  parameter int TIME_BITS     = DEF_TIME_BITS,
  parameter int COUNT_BITS    = DEF_COUNT_BITS,
  parameter int START_BACKOFF = DEF_START_BACKOFF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  item_t     item,
  input  cfg_regs_t cfg,
  output result_t   result
);

  localparam int UW = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;
  localparam logic [TIME_BITS-1:0]  START_T = TIME_BITS'(START_BACKOFF);
  localparam logic [TIME_BITS-1:0]  TIME_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [TIME_BITS-1:0] cell_min_left_r, cell_min_left_nxt;
  logic [TIME_BITS-1:0] cell_max_left_r, cell_max_left_nxt;
  logic [TIME_BITS-1:0] cell_retry_left_r, cell_retry_left_nxt;
  logic [TIME_BITS-1:0] cell_backoff_r, cell_backoff_nxt;
  logic [COUNT_BITS-1:0] cell_updates_r, cell_updates_nxt;
  logic [3:0] cell_flags_r, cell_flags_nxt;
  logic [TIME_BITS-1:0] sat_min_left_r, sat_min_left_nxt;
  logic [TIME_BITS-1:0] sat_max_left_r, sat_max_left_nxt;
  logic [TIME_BITS-1:0] pass_left_r, pass_left_nxt;
  logic [COUNT_BITS-1:0] sat_updates_r, sat_updates_nxt;
  logic [2:0] sat_flags_r, sat_flags_nxt;
  req_t awaiting_r, awaiting_nxt;

  // cell_flags bits
  localparam int CF_MIN = 0, CF_MAX = 1, CF_RETRY = 2, CF_BMAX = 3;
  // sat_flags bits
  localparam int SF_MIN = 0, SF_MAX = 1, SF_ARM = 2;

  logic [TIME_BITS-1:0] cell_min_t, cell_max_t, cell_lim_t;
  logic [TIME_BITS-1:0] sat_min_t, sat_max_t;
  logic cell_en, sat_en, pass_en;
  logic window, cell_rdy, sat_rdy;
  req_t req;

  assign cell_min_t = TIME_BITS'(cfg.cell_min_interval);
  assign cell_max_t = TIME_BITS'(cfg.cell_max_interval);
  assign cell_lim_t = TIME_BITS'(cfg.cell_backoff_limit);
  assign sat_min_t  = TIME_BITS'(cfg.sat_min_interval);
  assign sat_max_t  = TIME_BITS'(cfg.sat_max_interval);
  assign cell_en = cfg.mode_bits[MODE_CELL_EN];
  assign sat_en  = cfg.mode_bits[MODE_SAT_EN];
  assign pass_en = cfg.mode_bits[MODE_PASS_WIN];

  always_comb begin
    cell_min_left_nxt   = cell_min_left_r;
    cell_max_left_nxt   = cell_max_left_r;
    cell_retry_left_nxt = cell_retry_left_r;
    cell_backoff_nxt    = cell_backoff_r;
    cell_updates_nxt    = cell_updates_r;
    cell_flags_nxt      = cell_flags_r;
    sat_min_left_nxt    = sat_min_left_r;
    sat_max_left_nxt    = sat_max_left_r;
    pass_left_nxt       = pass_left_r;
    sat_updates_nxt     = sat_updates_r;
    sat_flags_nxt       = sat_flags_r;
    awaiting_nxt        = awaiting_r;
    window   = 1'b0;
    cell_rdy = 1'b0;
    sat_rdy  = 1'b0;
    req      = REQ_NONE;
    result   = '0;

    unique case (item.operation)
      OP_START: begin
        cell_min_left_nxt   = '0;
        cell_max_left_nxt   = '0;
        cell_retry_left_nxt = '0;
        cell_backoff_nxt    = START_T;
        cell_updates_nxt    = '0;
        cell_flags_nxt      = '0;
        sat_min_left_nxt    = '0;
        sat_max_left_nxt    = '0;
        pass_left_nxt       = '0;
        sat_updates_nxt     = '0;
        sat_flags_nxt       = '0;
        awaiting_nxt        = REQ_NONE;
        if (cell_en && cfg.cell_max_interval != '0) cell_max_left_nxt = cell_max_t;
        if (cell_en && cfg.cell_min_interval != '0) cell_min_left_nxt = cell_min_t;
        else cell_flags_nxt[CF_MIN] = 1'b1;
        if (sat_en && cfg.sat_max_interval != '0) sat_max_left_nxt = sat_max_t;
        if (sat_en && cfg.sat_min_interval != '0) sat_min_left_nxt = sat_min_t;
        else sat_flags_nxt[SF_MIN] = 1'b1;
      end

      OP_TICK: begin
        // Count every running timer down; reaching zero sets its flag
        if (cell_min_left_r != '0) begin
          cell_min_left_nxt = cell_min_left_r - 1'b1;
          if (cell_min_left_nxt == '0) cell_flags_nxt[CF_MIN] = 1'b1;
        end
        if (cell_max_left_r != '0) begin
          cell_max_left_nxt = cell_max_left_r - 1'b1;
          if (cell_max_left_nxt == '0) cell_flags_nxt[CF_MAX] = 1'b1;
        end
        if (cell_retry_left_r != '0) begin
          cell_retry_left_nxt = cell_retry_left_r - 1'b1;
          if (cell_retry_left_nxt == '0) cell_flags_nxt[CF_RETRY] = 1'b1;
        end
        if (sat_min_left_r != '0) begin
          sat_min_left_nxt = sat_min_left_r - 1'b1;
          if (sat_min_left_nxt == '0) sat_flags_nxt[SF_MIN] = 1'b1;
        end
        if (sat_max_left_r != '0) begin
          sat_max_left_nxt = sat_max_left_r - 1'b1;
          if (sat_max_left_nxt == '0) sat_flags_nxt[SF_MAX] = 1'b1;
        end
        // Armed pass window opens for this tick only
        if (sat_flags_r[SF_ARM]) begin
          if (pass_left_r <= TIME_BITS'(1)) begin
            pass_left_nxt = '0;
            sat_flags_nxt[SF_ARM] = 1'b0;
            window = 1'b1;
          end else begin
            pass_left_nxt = pass_left_r - 1'b1;
          end
        end

        if (cell_en && cell_flags_nxt[CF_MIN]) begin
          if (cell_flags_nxt[CF_RETRY]) cell_rdy = 1'b1;
          else if (cell_retry_left_nxt == '0) begin
            cell_rdy = cell_flags_nxt[CF_MAX] ||
                       (cfg.cell_min_updates != '0 &&
                        UW'(cell_updates_r) >= UW'(cfg.cell_min_updates));
          end
        end
        if (sat_en && sat_flags_nxt[SF_MIN] && (!pass_en || window)) begin
          sat_rdy = sat_flags_nxt[SF_MAX] ||
                    (cfg.sat_min_updates != '0 &&
                     UW'(sat_updates_r) >= UW'(cfg.sat_min_updates));
        end

        if (awaiting_r == REQ_NONE) begin
          if (cell_rdy && sat_rdy)
            req = cfg.mode_bits[MODE_CELL_WIN] ? REQ_CELL : REQ_SAT;
          else if (cell_rdy) req = REQ_CELL;
          else if (sat_rdy) req = REQ_SAT;
          if (req == REQ_CELL) cell_flags_nxt[CF_RETRY] = 1'b0;
          awaiting_nxt = req;
        end
        result.request = req;
      end

      OP_UPDATE: begin
        if (cell_en && cell_updates_r != COUNT_MAX) cell_updates_nxt = cell_updates_r + 1'b1;
        if (sat_en) begin
          if (sat_updates_r != COUNT_MAX) sat_updates_nxt = sat_updates_r + 1'b1;
          if (pass_en && !sat_flags_r[SF_ARM]) begin
            sat_flags_nxt[SF_ARM] = 1'b1;
            pass_left_nxt = TIME_BITS'(item.pass_delay);
          end
        end
      end

      OP_CELL_RESULT: begin
        if (awaiting_r == REQ_CELL) begin
          awaiting_nxt = REQ_NONE;
          if (item.success) begin
            if (cfg.cell_min_interval != '0) begin
              cell_flags_nxt[CF_MIN] = 1'b0;
              cell_min_left_nxt = cell_min_t;
            end
            if (cfg.sat_min_interval != '0) begin
              sat_flags_nxt[SF_MIN] = 1'b0;
              sat_min_left_nxt = sat_min_t;
            end
            if (cfg.cell_max_interval != '0) begin
              cell_flags_nxt[CF_MAX] = 1'b0;
              cell_max_left_nxt = cell_max_t;
            end
            cell_backoff_nxt = START_T;
            cell_flags_nxt[CF_BMAX] = 1'b0;
            cell_updates_nxt = '0;
          end else begin
            cell_max_left_nxt = '0;
            if (cell_backoff_r >= cell_lim_t) begin
              cell_backoff_nxt = cell_lim_t;
              cell_flags_nxt[CF_BMAX] = 1'b1;
              result.max_backoff_hit = 1'b1;
            end
            result.retry_wait   = TIME_W'(cell_backoff_nxt);
            cell_retry_left_nxt = cell_backoff_nxt;
            if (cell_backoff_nxt == '0) cell_flags_nxt[CF_RETRY] = 1'b1;
            // Double, saturating at the largest time value
            if (!cell_flags_nxt[CF_BMAX]) begin
              if (cell_backoff_nxt[TIME_BITS-1]) cell_backoff_nxt = TIME_MAX;
              else cell_backoff_nxt = {cell_backoff_nxt[TIME_BITS-2:0], 1'b0};
            end
          end
        end
      end

      OP_SAT_RESULT: begin
        if (awaiting_r == REQ_SAT) begin
          awaiting_nxt = REQ_NONE;
          if (item.success) begin
            if (cfg.cell_min_interval != '0) begin
              cell_flags_nxt[CF_MIN] = 1'b0;
              cell_min_left_nxt = cell_min_t;
            end
            if (cfg.sat_min_interval != '0) begin
              sat_flags_nxt[SF_MIN] = 1'b0;
              sat_min_left_nxt = sat_min_t;
            end
            sat_updates_nxt = '0;
          end
          if (cfg.sat_max_interval != '0) begin
            sat_flags_nxt[SF_MAX] = 1'b0;
            sat_max_left_nxt = sat_max_t;
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_min_left_r   <= '0;
      cell_max_left_r   <= '0;
      cell_retry_left_r <= '0;
      cell_backoff_r    <= START_T;
      cell_updates_r    <= '0;
      cell_flags_r      <= '0;
      sat_min_left_r    <= '0;
      sat_max_left_r    <= '0;
      pass_left_r       <= '0;
      sat_updates_r     <= '0;
      sat_flags_r       <= '0;
      awaiting_r        <= REQ_NONE;
    end else if (step_en) begin
      cell_min_left_r   <= cell_min_left_nxt;
      cell_max_left_r   <= cell_max_left_nxt;
      cell_retry_left_r <= cell_retry_left_nxt;
      cell_backoff_r    <= cell_backoff_nxt;
      cell_updates_r    <= cell_updates_nxt;
      cell_flags_r      <= cell_flags_nxt;
      sat_min_left_r    <= sat_min_left_nxt;
      sat_max_left_r    <= sat_max_left_nxt;
      pass_left_r       <= pass_left_nxt;
      sat_updates_r     <= sat_updates_nxt;
      sat_flags_r       <= sat_flags_nxt;
      awaiting_r        <= awaiting_nxt;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import duts_pkg::*;

  // Watchdog ceiling: roughly 960 beats, each paying a long input gap, a long
  // output stall and the pipeline, many times over.
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Two-stage pipeline; run on idle after the drain to catch any stray result beat.
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 8;
  localparam int BEATS_PER_PHASE = 110;
  localparam int MAX_REPORTS = 10;
  localparam int UPDATE_BURST = 40;
  localparam int UPDATE_THRESHOLD = 32;

  localparam logic [TIME_W-1:0]  TIME_MAX      = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [TIME_W-1:0]  BACKOFF_START = TIME_W'(DEF_START_BACKOFF);

  // Cellular flag bits
  localparam int CF_MIN   = 0;
  localparam int CF_MAX   = 1;
  localparam int CF_RETRY = 2;
  localparam int CF_BMAX  = 3;
  // Satellite flag bits
  localparam int SF_MIN = 0;
  localparam int SF_MAX = 1;
  localparam int SF_ARM = 2;

  // Operation codes outside the defined set; the block must ignore them
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_BOTH =
    MODE_W'((1 << MODE_CELL_EN) | (1 << MODE_SAT_EN));
  localparam logic [MODE_W-1:0] MODE_ALL  = '1;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata   = '0;   // [0] success, [24:1] pass_delay, rest zero
  logic [2:0]           in_tuser   = '0;   // [2:0] operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;         // [0] max_backoff_hit, [24:1] retry_wait
  logic [1:0]           out_tuser;         // [1:0] request
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [TIME_W-1:0]    cfg_data   = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dual_uplink_transmit_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow: configuration and state as the block should hold them
  // ---------------------------------------------------------------------------
  cfg_regs_t          sched_cfg;
  logic [TIME_W-1:0]  cmin_left, cmax_left, cretry_left, cbackoff;
  logic [TIME_W-1:0]  smin_left, smax_left, pass_left;
  logic [COUNT_W-1:0] cupdates, supdates;
  logic [3:0]         cflags;
  logic [2:0]         sflags;
  req_t               awaited;

  result_t     expected_results[$];
  int          error_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_on = 1'b1;   // clear for bursts with no gaps or stalls
  int          stall_left = 0;

  function automatic void wipe_schedule();
    cmin_left   = '0;
    cmax_left   = '0;
    cretry_left = '0;
    cbackoff    = BACKOFF_START;
    cupdates    = '0;
    cflags      = '0;
    smin_left   = '0;
    smax_left   = '0;
    pass_left   = '0;
    supdates    = '0;
    sflags      = '0;
    awaited     = REQ_NONE;
  endfunction

  // Decrement a running countdown; report when it has just reached zero.
  function automatic bit run_down(inout logic [TIME_W-1:0] left);
    if (left != '0) begin
      left = left - 1'b1;
      return left == '0;
    end
    return 1'b0;
  endfunction

  function automatic void rearm_min_timers();
    if (sched_cfg.cell_min_interval != '0) begin
      cflags[CF_MIN] = 1'b0;
      cmin_left = sched_cfg.cell_min_interval;
    end
    if (sched_cfg.sat_min_interval != '0) begin
      sflags[SF_MIN] = 1'b0;
      smin_left = sched_cfg.sat_min_interval;
    end
  endfunction

  function automatic bit cell_due();
    if (!sched_cfg.mode_bits[MODE_CELL_EN] || !cflags[CF_MIN]) return 1'b0;
    if (cflags[CF_RETRY]) return 1'b1;
    if (cretry_left != '0) return 1'b0;
    if (sched_cfg.cell_min_updates != '0 && cupdates >= sched_cfg.cell_min_updates)
      return 1'b1;
    return cflags[CF_MAX];
  endfunction

  function automatic bit sat_due(bit window);
    if (!sched_cfg.mode_bits[MODE_SAT_EN] || !sflags[SF_MIN]) return 1'b0;
    if (sched_cfg.mode_bits[MODE_PASS_WIN] && !window) return 1'b0;
    if (sched_cfg.sat_min_updates != '0 && supdates >= sched_cfg.sat_min_updates)
      return 1'b1;
    return sflags[SF_MAX];
  endfunction

  // Advance the shadow by one accepted beat and return the result it should give.
  function automatic result_t schedule_beat(logic [2:0] op, logic ok,
                                            logic [TIME_W-1:0] delay);
    result_t r;
    bit      window;
    bit      c, s;
    r = '0;
    window = 1'b0;
    case (op)
      OP_START: begin
        wipe_schedule();
        if (sched_cfg.mode_bits[MODE_CELL_EN] && sched_cfg.cell_max_interval != '0)
          cmax_left = sched_cfg.cell_max_interval;
        if (sched_cfg.mode_bits[MODE_CELL_EN] && sched_cfg.cell_min_interval != '0)
          cmin_left = sched_cfg.cell_min_interval;
        else
          cflags[CF_MIN] = 1'b1;
        if (sched_cfg.mode_bits[MODE_SAT_EN] && sched_cfg.sat_max_interval != '0)
          smax_left = sched_cfg.sat_max_interval;
        if (sched_cfg.mode_bits[MODE_SAT_EN] && sched_cfg.sat_min_interval != '0)
          smin_left = sched_cfg.sat_min_interval;
        else
          sflags[SF_MIN] = 1'b1;
      end
      OP_TICK: begin
        if (run_down(cmin_left))   cflags[CF_MIN]   = 1'b1;
        if (run_down(cmax_left))   cflags[CF_MAX]   = 1'b1;
        if (run_down(cretry_left)) cflags[CF_RETRY] = 1'b1;
        if (run_down(smin_left))   sflags[SF_MIN]   = 1'b1;
        if (run_down(smax_left))   sflags[SF_MAX]   = 1'b1;
        // An armed window with one tick or less left opens for this tick only
        if (sflags[SF_ARM]) begin
          if (pass_left <= 1) begin
            pass_left = '0;
            sflags[SF_ARM] = 1'b0;
            window = 1'b1;
          end else begin
            pass_left = pass_left - 1'b1;
          end
        end
        if (awaited == REQ_NONE) begin
          c = cell_due();
          s = sat_due(window);
          if (c && s)
            r.request = sched_cfg.mode_bits[MODE_CELL_WIN] ? REQ_CELL : REQ_SAT;
          else if (c)
            r.request = REQ_CELL;
          else if (s)
            r.request = REQ_SAT;
          if (r.request == REQ_CELL) cflags[CF_RETRY] = 1'b0;
          awaited = r.request;
        end
      end
      OP_UPDATE: begin
        if (sched_cfg.mode_bits[MODE_CELL_EN] && cupdates != COUNT_MAX)
          cupdates = cupdates + 1'b1;
        if (sched_cfg.mode_bits[MODE_SAT_EN]) begin
          if (supdates != COUNT_MAX) supdates = supdates + 1'b1;
          if (sched_cfg.mode_bits[MODE_PASS_WIN] && !sflags[SF_ARM]) begin
            sflags[SF_ARM] = 1'b1;
            pass_left = delay;
          end
        end
      end
      OP_CELL_RESULT: begin
        if (awaited == REQ_CELL) begin
          awaited = REQ_NONE;
          if (ok) begin
            rearm_min_timers();
            if (sched_cfg.cell_max_interval != '0) begin
              cflags[CF_MAX] = 1'b0;
              cmax_left = sched_cfg.cell_max_interval;
            end
            cbackoff = BACKOFF_START;
            cflags[CF_BMAX] = 1'b0;
            cupdates = '0;
          end else begin
            // Failure drops the max countdown but keeps its flag
            cmax_left = '0;
            if (cbackoff >= sched_cfg.cell_backoff_limit) begin
              cbackoff = sched_cfg.cell_backoff_limit;
              cflags[CF_BMAX] = 1'b1;
              r.max_backoff_hit = 1'b1;
            end
            r.retry_wait = cbackoff;
            cretry_left = cbackoff;
            if (cbackoff == '0) cflags[CF_RETRY] = 1'b1;
            if (!cflags[CF_BMAX])
              cbackoff = (cbackoff > (TIME_MAX >> 1)) ? TIME_MAX : (cbackoff << 1);
          end
        end
      end
      OP_SAT_RESULT: begin
        if (awaited == REQ_SAT) begin
          awaited = REQ_NONE;
          if (ok) begin
            rearm_min_timers();
            supdates = '0;
          end
          if (sched_cfg.sat_max_interval != '0) begin
            sflags[SF_MAX] = 1'b0;
            smax_left = sched_cfg.sat_max_interval;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly short, now and then long
  function automatic int pick_len();
    return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(6, 30);
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(99) >= 25) return 0;
    return pick_len();
  endfunction

  function automatic logic [TIME_W-1:0] rand_wide();
    logic [31:0] w;
    w = $urandom();
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_interval();
    int r;
    r = $urandom_range(99);
    if (r < 40) return TIME_W'($urandom_range(0, 3));
    if (r < 70) return TIME_W'($urandom_range(4, 12));
    if (r < 85) return TIME_W'($urandom_range(13, 60));
    if (r < 95) return rand_wide();
    return TIME_MAX;
  endfunction

  function automatic logic [COUNT_W-1:0] rand_updates();
    int          r;
    logic [31:0] w;
    r = $urandom_range(99);
    w = $urandom();
    if (r < 40) return '0;
    if (r < 80) return COUNT_W'($urandom_range(1, 4));
    if (r < 95) return COUNT_W'($urandom_range(5, 20));
    if (r < 98) return w[COUNT_W-1:0];
    return COUNT_MAX;
  endfunction

  function automatic logic [TIME_W-1:0] rand_limit();
    case ($urandom_range(6))
      0: return '0;
      1: return TIME_W'(1);
      2: return BACKOFF_START;
      3: return TIME_W'($urandom_range(31, 59));
      4: return TIME_W'($urandom_range(60, 130));
      5: return rand_wide();
      default: return TIME_MAX;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_delay();
    int r;
    r = $urandom_range(99);
    if (r < 50) return TIME_W'($urandom_range(0, 3));
    if (r < 80) return TIME_W'($urandom_range(4, 20));
    if (r < 95) return rand_wide();
    return TIME_MAX;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one input beat; predict its result once the handshake completes.
  task automatic send_beat(logic [2:0] op, logic ok, logic [TIME_W-1:0] delay);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, delay, ok};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(schedule_beat(op, ok, delay));
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Write all eight registers in index order; only call with the block idle.
  task automatic load_settings(cfg_regs_t c);
    reg_idx_t          idx;
    logic [TIME_W-1:0] val;
    int                gap;
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_CELL_MIN_INTERVAL:  val = c.cell_min_interval;
        REG_CELL_MAX_INTERVAL:  val = c.cell_max_interval;
        REG_CELL_MIN_UPDATES:   val = {8'd0, c.cell_min_updates};
        REG_CELL_BACKOFF_LIMIT: val = c.cell_backoff_limit;
        REG_SAT_MIN_INTERVAL:   val = c.sat_min_interval;
        REG_SAT_MAX_INTERVAL:   val = c.sat_max_interval;
        REG_SAT_MIN_UPDATES:    val = {8'd0, c.sat_min_updates};
        default:                val = {20'd0, c.mode_bits};
      endcase
      gap = pick_gap();
      if (gap != 0) begin
        cfg_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    sched_cfg = c;
  endtask

  task automatic flag_error(string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Result sink: random stalls, mostly short, a few long
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= pick_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("result beat with nothing expected (req %0d wait %0d)",
                             out_tuser, out_tdata[24:1]));
      end else begin
        want = expected_results.pop_front();
        if (out_tuser != want.request)
          flag_error($sformatf("request expected %0d got %0d", want.request, out_tuser));
        if (out_tdata[0] != want.max_backoff_hit)
          flag_error($sformatf("max_backoff_hit expected %0b got %0b",
                               want.max_backoff_hit, out_tdata[0]));
        if (out_tdata[24:1] != want.retry_wait)
          flag_error($sformatf("retry_wait expected %0d got %0d",
                               want.retry_wait, out_tdata[24:1]));
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Without a start beat the min flags are clear: nothing may be requested.
  task automatic test_idle_before_start();
    cfg_regs_t c;
    c = '0;
    c.cell_max_interval = TIME_W'(1);
    c.cell_min_updates  = COUNT_W'(1);
    c.sat_max_interval  = TIME_W'(1);
    c.sat_min_updates   = COUNT_W'(1);
    c.cell_backoff_limit = BACKOFF_START;
    c.mode_bits = MODE_ALL;
    load_settings(c);
    send_beat(OP_TICK, 1'b0, '0);
    send_beat(OP_UPDATE, 1'b0, '0);
    send_beat(OP_TICK, 1'b1, '0);
    send_beat(OP_CELL_RESULT, 1'b1, '0);
    send_beat(OP_SAT_RESULT, 1'b0, '0);
    send_beat(OP_TICK, 1'b0, '0);
    drain_results();
  endtask

  // Walk the corner cases: pass window from a zero delay, stray result,
  // zero backoff limit giving an instant retry, unknown codes, tie priority.
  task automatic test_directed_cases();
    cfg_regs_t c;
    c = '0;
    c.cell_min_interval = TIME_W'(1);
    c.cell_max_interval = TIME_W'(2);
    c.sat_min_updates   = COUNT_W'(1);
    c.mode_bits = MODE_W'((1 << MODE_CELL_EN) | (1 << MODE_SAT_EN) | (1 << MODE_PASS_WIN));
    load_settings(c);
    send_beat(OP_START, 1'b0, '0);
    send_beat(OP_UPDATE, 1'b0, '0);        // zero delay: window on the next tick
    send_beat(OP_TICK, 1'b0, '0);
    send_beat(OP_TICK, 1'b0, '0);
    send_beat(OP_CELL_RESULT, 1'b0, '0);   // satellite awaited, so ignored
    send_beat(OP_SAT_RESULT, 1'b1, '0);
    send_beat(OP_TICK, 1'b0, '0);
    send_beat(OP_CELL_RESULT, 1'b0, '0);   // clamps to zero backoff
    send_beat(OP_TICK, 1'b0, '0);
    send_beat(OP_CELL_RESULT, 1'b1, '0);
    for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++)
      send_beat(op[2:0], 1'b1, TIME_MAX);
    send_beat(OP_UPDATE, 1'b1, TIME_MAX);
    send_beat(OP_TICK, 1'b0, '0);
    drain_results();

    // Both radios ready on the same tick; cellular takes it
    c.cell_min_updates = COUNT_W'(1);
    c.cell_backoff_limit = TIME_MAX;
    c.mode_bits = MODE_BOTH | MODE_W'(1 << MODE_CELL_WIN);
    load_settings(c);
    send_beat(OP_START, 1'b0, '0);
    send_beat(OP_UPDATE, 1'b0, '0);
    send_beat(OP_TICK, 1'b0, '0);
    send_beat(OP_CELL_RESULT, 1'b0, '0);
    send_beat(OP_TICK, 1'b0, '0);
    drain_results();
  endtask

  // Drive both update counters past their thresholds with a flat-out burst.
  task automatic test_update_threshold();
    cfg_regs_t c;
    c = '0;
    c.cell_min_updates = COUNT_W'(UPDATE_THRESHOLD);
    c.sat_min_updates  = COUNT_W'(UPDATE_THRESHOLD);
    c.cell_backoff_limit = BACKOFF_START;
    c.mode_bits = MODE_BOTH;
    load_settings(c);
    idle_on = 1'b0;
    send_beat(OP_START, 1'b0, '0);
    for (int i = 0; i < UPDATE_BURST; i++)
      send_beat(OP_UPDATE, 1'b0, rand_delay());
    send_beat(OP_TICK, 1'b0, '0);          // tie goes to satellite
    send_beat(OP_SAT_RESULT, 1'b1, '0);
    send_beat(OP_TICK, 1'b0, '0);          // cellular count still past threshold
    send_beat(OP_CELL_RESULT, 1'b1, '0);
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic random_beat();
    int                r;
    logic              ok;
    logic [TIME_W-1:0] d;
    logic [2:0]        bad;
    ok  = ($urandom_range(99) < 60);
    d   = rand_delay();
    bad = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
    r   = $urandom_range(99);
    // Answer outstanding requests most of the time to get deep into retries
    if (awaited == REQ_CELL && r < 55) begin
      send_beat(OP_CELL_RESULT, ok, d);
    end else if (awaited == REQ_SAT && r < 55) begin
      send_beat(OP_SAT_RESULT, ok, d);
    end else begin
      r = $urandom_range(99);
      if (r < 55)      send_beat(OP_TICK, ok, d);
      else if (r < 75) send_beat(OP_UPDATE, ok, d);
      else if (r < 84) send_beat(OP_CELL_RESULT, ok, d);
      else if (r < 93) send_beat(OP_SAT_RESULT, ok, d);
      else if (r < 97) send_beat(OP_START, ok, d);
      else             send_beat(bad, ok, d);
    end
  endtask

  // Phases of random traffic, each under fresh settings; the first two at the extremes.
  task automatic test_random_phases();
    cfg_regs_t c;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        c = '1;
      end else if (p == 1) begin
        c = '0;
      end else begin
        c.cell_min_interval  = rand_interval();
        c.cell_max_interval  = rand_interval();
        c.cell_min_updates   = rand_updates();
        c.cell_backoff_limit = rand_limit();
        c.sat_min_interval   = rand_interval();
        c.sat_max_interval   = rand_interval();
        c.sat_min_updates    = rand_updates();
        c.mode_bits = MODE_W'($urandom_range(15));
        if ($urandom_range(99) < 70) c.mode_bits = c.mode_bits | MODE_BOTH;
      end
      load_settings(c);
      if ($urandom_range(9) != 0) send_beat(OP_START, 1'b0, rand_delay());
      for (int i = 0; i < BEATS_PER_PHASE; i++) begin
        // Switch now and then to a stretch with no gaps or stalls
        if (i % 30 == 0) idle_on = ($urandom_range(3) != 0);
        random_beat();
      end
      idle_on = 1'b1;
      drain_results();
    end
  endtask

  initial begin
    sched_cfg = '0;
    wipe_schedule();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_before_start();
    test_directed_cases();
    test_update_threshold();
    test_random_phases();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
